// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared constants, register indexes and defaults of the RTT timeout estimator.
// ----------------------------------------------------------------------------
package rtt_pkg;

    // Default time and fraction widths.
    localparam int TIME_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF = 8;

    // The gains are Q1.15 values, so 1.0 is 32768.
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_SHIFT = 15;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

    // Reset values of the configuration registers.
    localparam logic [GAIN_BITS-1:0] ALPHA_RST = 16'd4096;
    localparam logic [GAIN_BITS-1:0] BETA_RST  = 16'd8192;
    localparam longint INIT_RTT_RST = 100000;
    localparam longint INIT_VAR_RST = 50000;
    localparam longint MIN_TO_RST   = 200000;
    localparam longint MAX_TO_RST   = 16777215;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALPHA    = 3'd0,
        CFG_BETA     = 3'd1,
        CFG_INIT_RTT = 3'd2,
        CFG_INIT_VAR = 3'd3,
        CFG_MIN_TO   = 3'd4,
        CFG_MAX_TO   = 3'd5
    } t_cfg_idx;

    // A gain register above 1.0 acts as 1.0.
    function automatic logic [GAIN_BITS-1:0] sat_gain(input logic [GAIN_BITS-1:0] g);
        sat_gain = (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

// ===== sv/rtt_blend.sv =====
// ----------------------------------------------------------------------------
// rtt_blend
// One exponential blend step: old + ((target - old) * gain) >>> 15, which
// equals the truncated ((1 - gain) * old + gain * target) >> 15.
// ----------------------------------------------------------------------------
module rtt_blend #(
    parameter int W = rtt_pkg::TIME_BITS_DEF + rtt_pkg::FRAC_BITS_DEF
) (
    input  logic [W-1:0]                  i_old,
    input  logic [W-1:0]                  i_target,
    input  logic [rtt_pkg::GAIN_BITS-1:0] i_gain,
    output logic [W-1:0]                  o_new
);
    import rtt_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = DW + GAIN_BITS + 1;

    logic signed [DW-1:0] w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_step;
    logic signed [PW-1:0] w_sum;

    // With a gain of at most 1.0, floor division by 32768 keeps the result in the
    // range spanned by the two operands.
    assign w_diff = $signed({1'b0, i_target}) - $signed({1'b0, i_old});
    assign w_prod = PW'(w_diff) * $signed(PW'({1'b0, i_gain}));
    assign w_step = w_prod >>> GAIN_SHIFT;
    assign w_sum  = w_step + $signed(PW'(i_old));
    assign o_new  = w_sum[W-1:0];

endmodule

// ===== sv/rtt_timeout_estimator.sv =====
// ----------------------------------------------------------------------------
// rtt_timeout_estimator
// Fixed-point Jacobson/Karels retransmission timeout estimator.
// ----------------------------------------------------------------------------
// Each input beat carries one round-trip-time sample in microseconds and
// produces exactly one output beat with the clamped retransmission timeout and
// the integer parts of the updated smoothed RTT and RTT variation. The block
// takes one sample every clock cycle while the result channel is not stalled.
// A taken sample is loaded into the input register, updates the state as it
// moves on to stage two, and then loads the output register with the clamped
// timeout. The clock rate is set by the state update loop, which subtracts,
// multiplies by a 16-bit gain and adds combinationally so that the next
// sample sees the new state. Configuration writes are taken at
// any time but should be made only while no sample is in flight; writing the
// initial RTT or initial variation register reloads the smoothed RTT and the
// variation, while new clamp limits apply from the next sample on.
// ----------------------------------------------------------------------------
module rtt_timeout_estimator #(
    parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = rtt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [rtt_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [TIME_BITS-1:0]           i_cfg_wdata,
    // Sample channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [TIME_BITS-1:0]           i_sample_us,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [TIME_BITS-1:0]           o_timeout_us,
    output logic [TIME_BITS-1:0]           o_smoothed_us,
    output logic [TIME_BITS-1:0]           o_variation_us
);
    import rtt_pkg::*;

    localparam int W  = TIME_BITS + FRAC_BITS;   // state width
    localparam int SW = W + 3;                   // smoothed plus four variations
    localparam int TW = TIME_BITS + 3;           // timeout before clamping

    // Configuration registers.
    logic [GAIN_BITS-1:0] r_alpha;
    logic [GAIN_BITS-1:0] r_beta;
    logic [TIME_BITS-1:0] r_init_rtt;
    logic [TIME_BITS-1:0] r_init_var;
    logic [TIME_BITS-1:0] r_min_to;
    logic [TIME_BITS-1:0] r_max_to;

    // Estimator state, FRAC_BITS fraction bits.
    logic [W-1:0] r_sm_q;
    logic [W-1:0] r_var_q;

    // Pipeline registers.
    logic                 r_s1_valid;
    logic [TIME_BITS-1:0] r_s1_sample;
    logic                 r_s2_valid;
    logic                 r_out_valid;
    logic [TIME_BITS-1:0] r_timeout;
    logic [TIME_BITS-1:0] r_smoothed;
    logic [TIME_BITS-1:0] r_variation;

    logic [W-1:0]  w_sample_q;
    logic [W-1:0]  w_err;
    logic [W-1:0]  n_sm_q;
    logic [W-1:0]  n_var_q;
    logic [SW-1:0] w_sum;
    logic [TW-1:0] w_raw_to;
    logic [TW-1:0] w_lo_to;
    logic [TIME_BITS-1:0] n_timeout;

    logic w_out_ready;
    logic w_s2_ready;
    logic w_s1_go;
    logic w_s2_go;
    logic w_in_go;

    // Back-pressure runs from the output register toward the input. The
    // state update happens when the sample leaves the input register, and a
    // stage only moves forward when the next one has room, so the state held
    // in r_sm_q and r_var_q is always the one that belongs to stage two.
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign w_s1_go     = r_s1_valid && w_s2_ready;
    assign w_s2_go     = r_s2_valid && w_out_ready;
    assign o_in_stall  = r_s1_valid && !w_s2_ready;
    assign w_in_go     = i_in_valid && !o_in_stall;

    // The variation moves toward the absolute error against the old smoothed
    // RTT, and the smoothed RTT moves toward the sample; both use the old
    // smoothed value, so the two blends run side by side.
    assign w_sample_q = W'(r_s1_sample) << FRAC_BITS;
    assign w_err      = (w_sample_q >= r_sm_q) ? (w_sample_q - r_sm_q)
                                               : (r_sm_q - w_sample_q);

    rtt_blend #(.W(W)) u_var_blend (
        .i_old    (r_var_q),
        .i_target (w_err),
        .i_gain   (sat_gain(r_beta)),
        .o_new    (n_var_q)
    );

    rtt_blend #(.W(W)) u_sm_blend (
        .i_old    (r_sm_q),
        .i_target (w_sample_q),
        .i_gain   (sat_gain(r_alpha)),
        .o_new    (n_sm_q)
    );

    // Timeout from the updated state. The lower clamp goes first and the
    // upper clamp last, so crossed limits give the maximum.
    assign w_sum    = SW'(r_sm_q) + (SW'(r_var_q) << 2);
    assign w_raw_to = w_sum[SW-1:FRAC_BITS];
    assign w_lo_to  = (w_raw_to < TW'(r_min_to)) ? TW'(r_min_to) : w_raw_to;
    assign n_timeout = (w_lo_to > TW'(r_max_to)) ? r_max_to : w_lo_to[TIME_BITS-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RST;
            r_beta     <= BETA_RST;
            r_init_rtt <= TIME_BITS'(INIT_RTT_RST);
            r_init_var <= TIME_BITS'(INIT_VAR_RST);
            r_min_to   <= TIME_BITS'(MIN_TO_RST);
            r_max_to   <= TIME_BITS'(MAX_TO_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA:    r_alpha    <= i_cfg_wdata[GAIN_BITS-1:0];
                CFG_BETA:     r_beta     <= i_cfg_wdata[GAIN_BITS-1:0];
                CFG_INIT_RTT: r_init_rtt <= i_cfg_wdata;
                CFG_INIT_VAR: r_init_var <= i_cfg_wdata;
                CFG_MIN_TO:   r_min_to   <= i_cfg_wdata;
                CFG_MAX_TO:   r_max_to   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Estimator state: reloaded from the initial registers on reset or when
    // either of them is written, updated when a sample enters stage two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_q  <= W'(TIME_BITS'(INIT_RTT_RST)) << FRAC_BITS;
            r_var_q <= W'(TIME_BITS'(INIT_VAR_RST)) << FRAC_BITS;
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_INIT_RTT)) begin
            r_sm_q  <= W'(i_cfg_wdata) << FRAC_BITS;
            r_var_q <= W'(r_init_var) << FRAC_BITS;
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_INIT_VAR)) begin
            r_sm_q  <= W'(r_init_rtt) << FRAC_BITS;
            r_var_q <= W'(i_cfg_wdata) << FRAC_BITS;
        end else if (w_s1_go) begin
            r_sm_q  <= n_sm_q;
            r_var_q <= n_var_q;
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_go) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_go) begin
                r_out_valid <= 1'b1;
            end else if (w_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_go) begin
            r_s1_sample <= i_sample_us;
        end
        if (w_s2_go) begin
            r_timeout   <= n_timeout;
            r_smoothed  <= r_sm_q[W-1:FRAC_BITS];
            r_variation <= r_var_q[W-1:FRAC_BITS];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_timeout_us   = r_timeout;
    assign o_smoothed_us  = r_smoothed;
    assign o_variation_us = r_variation;

    // The timeout never exceeds the upper clamp.
    a_to_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_timeout_us <= r_max_to))
        else $error("timeout above upper clamp");

    // With ordered clamps the timeout never falls below the lower clamp.
    a_to_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_min_to <= r_max_to)) |-> (o_timeout_us >= r_min_to))
        else $error("timeout below lower clamp");

    // A sample waiting in the input register is not lost when stage two is full.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_go) |=> r_s1_valid)
        else $error("input stage dropped a sample");

    // The smoothed RTT stays between its old value and the sample.
    a_sm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && !i_cfg_we) |=>
            ((r_sm_q <= $past(r_sm_q)) || (r_sm_q <= $past(w_sample_q))) &&
            ((r_sm_q >= $past(r_sm_q)) || (r_sm_q >= $past(w_sample_q))))
        else $error("smoothed RTT left the blend range");

endmodule

// ===== tb/sv/rtt_timeout_estimator_tb.sv =====
// ----------------------------------------------------------------------------
// rtt_timeout_estimator_tb
// Self-checking testbench for the RTT retransmission timeout estimator.
// ----------------------------------------------------------------------------
// A queue of RTT samples feeds a clocked driver, and a clocked monitor checks
// every result beat against an in-bench estimator. That estimator keeps its
// own smoothed RTT and RTT variation in Q8 and its own copy of the registers.
// A short directed part covers the sample extremes, gains of zero, one and
// above one, register values wider than the register, crossed clamps, writes
// to unused indexes and the largest initial state. The random part follows,
// in blocks, each after random register writes, under four idle patterns.
// ----------------------------------------------------------------------------
module rtt_timeout_estimator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TB_TIME        = rtt_pkg::TIME_BITS_DEF;
    localparam int     TB_FRAC        = rtt_pkg::FRAC_BITS_DEF;
    localparam longint TIME_MAX       = (longint'(1) << TB_TIME) - 1;
    localparam int     CLK_PERIOD     = 20;
    localparam int     RESET_CYCLES   = 4;
    localparam int     RAND_BLOCKS    = 20;
    localparam int     BLOCK_ITEMS    = 52;
    localparam int     REPORT_LIMIT   = 10;
    // The block presents a result once a taken sample has passed its input register, stage two and output register.
    localparam int     DRAIN_CYCLES   = 8;
    // A correct run stays far below this limit without a beat,
    // even under the heaviest idle pattern.
    localparam int     WATCHDOG_LIMIT = 4000;

    // Register indexes that decode to nothing. Writes to them must be ignored.
    localparam logic [rtt_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [rtt_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [TB_TIME-1:0] timeout;
        logic [TB_TIME-1:0] smoothed;
        logic [TB_TIME-1:0] variation;
    } t_rtt_result;

    // Block inputs, all known from time zero.
    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [rtt_pkg::CFG_IDX_BITS-1:0] i_cfg_idx   = '0;
    logic [TB_TIME-1:0]               i_cfg_wdata = '0;
    logic                             i_in_valid  = 1'b0;
    logic [TB_TIME-1:0]               i_sample_us = '0;
    logic                             i_out_stall = 1'b0;

    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [TB_TIME-1:0]               o_timeout_us;
    logic [TB_TIME-1:0]               o_smoothed_us;
    logic [TB_TIME-1:0]               o_variation_us;

    // Estimator state and register mirror.
    logic [15:0]        alpha_reg;
    logic [15:0]        beta_reg;
    logic [TB_TIME-1:0] init_rtt_reg;
    logic [TB_TIME-1:0] init_var_reg;
    logic [TB_TIME-1:0] min_to_reg;
    logic [TB_TIME-1:0] max_to_reg;
    logic [63:0]        smoothed_q8;
    logic [63:0]        variation_q8;

    logic [TB_TIME-1:0] pending_samples[$];
    t_rtt_result        estimates_due[$];

    int  items_queued  = 0;
    int  items_taken   = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;
    int  fail_count    = 0;
    int  idle_cycles   = 0;
    int  in_idle_pct   = 0;
    int  out_stall_pct = 0;
    // Set at each rising edge when a sample beat is taken; the driver reads it
    // at the following falling edge to decide whether to present a new beat.
    logic in_fire = 1'b0;

    rtt_timeout_estimator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_us    (i_sample_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_timeout_us   (o_timeout_us),
        .o_smoothed_us  (o_smoothed_us),
        .o_variation_us (o_variation_us)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Estimator
    // ------------------------------------------------------------------------

    // Loads the smoothed RTT and the variation from the initial registers.
    function automatic void reload_estimate();
        smoothed_q8  = 64'(init_rtt_reg) << TB_FRAC;
        variation_q8 = 64'(init_var_reg) << TB_FRAC;
    endfunction

    // Q1.15 blend of old toward target, exact and then truncated. A gain above
    // one acts as one.
    function automatic logic [63:0] gain_mix(input logic [63:0] old_q,
                                             input logic [63:0] target_q,
                                             input logic [15:0] gain);
        logic [63:0] eff;
        eff = (gain > rtt_pkg::GAIN_ONE) ? 64'(rtt_pkg::GAIN_ONE) : 64'(gain);
        return ((64'(rtt_pkg::GAIN_ONE) - eff) * old_q + eff * target_q)
               >> rtt_pkg::GAIN_SHIFT;
    endfunction

    // Advances the estimate by one sample and returns the expected result.
    function automatic t_rtt_result update_estimate(input logic [TB_TIME-1:0] sample);
        logic [63:0] sample_q8;
        logic [63:0] err_q8;
        logic [63:0] rto;
        t_rtt_result res;
        sample_q8 = 64'(sample) << TB_FRAC;
        err_q8 = (sample_q8 >= smoothed_q8) ? sample_q8 - smoothed_q8
                                             : smoothed_q8 - sample_q8;
        // The variation uses the error against the smoothed RTT before update.
        variation_q8 = gain_mix(variation_q8, err_q8, beta_reg);
        smoothed_q8  = gain_mix(smoothed_q8, sample_q8, alpha_reg);
        rto = (smoothed_q8 + 4 * variation_q8) >> TB_FRAC;
        // The upper clamp is applied last, so it wins when the clamps cross.
        if (rto < 64'(min_to_reg)) rto = 64'(min_to_reg);
        if (rto > 64'(max_to_reg)) rto = 64'(max_to_reg);
        res.timeout   = rto[TB_TIME-1:0];
        res.smoothed  = smoothed_q8[TB_FRAC +: TB_TIME];
        res.variation = variation_q8[TB_FRAC +: TB_TIME];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: presents queued samples at the falling edge. A beat stays
    // on the bus until it is taken; gaps are drawn independently of stall.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_sample_us <= pending_samples.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result beats against the oldest expectation, predicts a
    // result for every sample beat taken, and watches for a hung handshake.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rtt_result got;
        t_rtt_result want;
        logic        out_fire;
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (out_fire) begin
            got = '{timeout: o_timeout_us, smoothed: o_smoothed_us,
                    variation: o_variation_us};
            results_seen++;
            if (estimates_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result beat: timeout %0d smoothed %0d var %0d",
                             $realtime, got.timeout, got.smoothed, got.variation);
            end else begin
                want = estimates_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"[%0t] result %0d mismatch: timeout exp %0d got %0d, ",
                                  "smoothed exp %0d got %0d, var exp %0d got %0d"},
                                 $realtime, results_seen, want.timeout, got.timeout,
                                 want.smoothed, got.smoothed, want.variation,
                                 got.variation);
                end
            end
        end
        if (in_fire) begin
            items_taken++;
            estimates_due.push_back(update_estimate(i_sample_us));
        end
        if (in_fire || out_fire || i_cfg_we || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no beat for %0d cycles, %0d results still due",
                         $realtime, idle_cycles, estimates_due.size());
                $display("FAIL rtt_timeout_estimator");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Register write, made only while no sample is in flight. The mirror is
    // updated once the write edge has passed.
    task automatic write_reg(input logic [rtt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [TB_TIME-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            rtt_pkg::CFG_ALPHA:    alpha_reg = data[15:0];
            rtt_pkg::CFG_BETA:     beta_reg  = data[15:0];
            rtt_pkg::CFG_INIT_RTT: begin
                init_rtt_reg = data;
                reload_estimate();
            end
            rtt_pkg::CFG_INIT_VAR: begin
                init_var_reg = data;
                reload_estimate();
            end
            rtt_pkg::CFG_MIN_TO:   min_to_reg = data;
            rtt_pkg::CFG_MAX_TO:   max_to_reg = data;
            default: ;
        endcase
    endtask

    task automatic queue_sample(input logic [TB_TIME-1:0] sample);
        pending_samples.push_back(sample);
        items_queued++;
    endtask

    // Returns once every queued sample is taken and every result has arrived.
    task automatic drain();
        while (items_taken != items_queued || estimates_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end
            IDLE_SENDER: begin
                in_idle_pct = 86;
                out_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                in_idle_pct = 0;
                out_stall_pct = 86;
            end
            default: begin
                in_idle_pct = 21;
                out_stall_pct = 21;
            end
        endcase
    endtask

    // A time value: extremes, small values, jitter around a center, or any.
    function automatic logic [TB_TIME-1:0] pick_time(input int unsigned center);
        longint span;
        longint v;
        span = longint'(center) / 4 + 16;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = TIME_MAX;
            2, 3:    v = $urandom_range(4095);
            4, 5, 6: v = longint'(center) + longint'($urandom_range(int'(2 * span))) - span;
            default: v = $urandom_range(int'(TIME_MAX));
        endcase
        if (v < 0) v = 0;
        if (v > TIME_MAX) v = TIME_MAX;
        return v[TB_TIME-1:0];
    endfunction

    // A gain value, including values above one and values wider than 16 bits.
    function automatic logic [TB_TIME-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return TB_TIME'(rtt_pkg::GAIN_ONE);
            2:       return TB_TIME'(32767);
            3:       return TB_TIME'($urandom_range(512));
            4:       return TB_TIME'($urandom_range(65535, 32769));
            5:       return TB_TIME'($urandom());
            default: return TB_TIME'($urandom_range(32768));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned base;
        int          blk;
        int          n;

        alpha_reg    = rtt_pkg::ALPHA_RST;
        beta_reg     = rtt_pkg::BETA_RST;
        init_rtt_reg = TB_TIME'(rtt_pkg::INIT_RTT_RST);
        init_var_reg = TB_TIME'(rtt_pkg::INIT_VAR_RST);
        min_to_reg   = TB_TIME'(rtt_pkg::MIN_TO_RST);
        max_to_reg   = TB_TIME'(rtt_pkg::MAX_TO_RST);
        reload_estimate();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: sample extremes, a sample equal to the initial RTT,
        // and alternating bit patterns.
        set_idling(IDLE_NONE);
        queue_sample('0);
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample(TB_TIME'(rtt_pkg::INIT_RTT_RST));
        queue_sample(TB_TIME'(1));
        queue_sample(TB_TIME'(800000));
        queue_sample(24'h555555);
        queue_sample(24'hAAAAAA);
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample('0);
        drain();

        // A wide value on a gain register keeps only its low 16 bits; here that
        // is above one and saturates, so the smoothed RTT follows the sample.
        write_reg(rtt_pkg::CFG_ALPHA, 24'hFFFFFF);
        write_reg(rtt_pkg::CFG_BETA, TB_TIME'(rtt_pkg::GAIN_ONE));
        set_idling(IDLE_BOTH);
        queue_sample('0);
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample(TB_TIME'(12345));
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample('0);
        drain();

        // Zero gains freeze the state. Crossed clamps leave only the upper one.
        // Writes to unused indexes must change nothing.
        write_reg(rtt_pkg::CFG_ALPHA, '0);
        write_reg(rtt_pkg::CFG_BETA, '0);
        write_reg(rtt_pkg::CFG_MIN_TO, TB_TIME'(TIME_MAX));
        write_reg(rtt_pkg::CFG_MAX_TO, '0);
        write_reg(CFG_IDX_SPARE_A, 24'h000001);
        write_reg(CFG_IDX_SPARE_B, 24'hFFFFFF);
        set_idling(IDLE_SENDER);
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample('0);
        queue_sample(TB_TIME'(500));
        drain();

        // Largest initial state: smoothed plus four times the variation needs
        // more than TIME_BITS before the clamp.
        write_reg(rtt_pkg::CFG_INIT_RTT, TB_TIME'(TIME_MAX));
        write_reg(rtt_pkg::CFG_INIT_VAR, TB_TIME'(TIME_MAX));
        write_reg(rtt_pkg::CFG_MIN_TO, '0);
        write_reg(rtt_pkg::CFG_MAX_TO, TB_TIME'(TIME_MAX));
        write_reg(rtt_pkg::CFG_ALPHA, TB_TIME'(32767));
        write_reg(rtt_pkg::CFG_BETA, TB_TIME'(1));
        set_idling(IDLE_RECEIVER);
        queue_sample('0);
        queue_sample(TB_TIME'(TIME_MAX));
        queue_sample('0);
        queue_sample(TB_TIME'(1));
        drain();

        // Random blocks, each with its own settings and idle pattern. Samples
        // mostly scatter around an RTT level so the estimator settles and
        // tracks, with outliers and extremes mixed in.
        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            base = ($urandom_range(3) == 0) ? $urandom_range(int'(TIME_MAX))
                                            : $urandom_range(2000000);
            if ($urandom_range(99) < 60) write_reg(rtt_pkg::CFG_ALPHA, pick_gain());
            if ($urandom_range(99) < 60) write_reg(rtt_pkg::CFG_BETA, pick_gain());
            if ($urandom_range(99) < 50) write_reg(rtt_pkg::CFG_INIT_RTT, TB_TIME'(base));
            if ($urandom_range(99) < 50)
                write_reg(rtt_pkg::CFG_INIT_VAR,
                          ($urandom_range(3) == 0) ? pick_time(base) : TB_TIME'(base / 2));
            if ($urandom_range(99) < 50)
                write_reg(rtt_pkg::CFG_MIN_TO,
                          ($urandom_range(3) == 0) ? pick_time(base)
                                                   : TB_TIME'($urandom_range(400000)));
            if ($urandom_range(99) < 50)
                write_reg(rtt_pkg::CFG_MAX_TO,
                          ($urandom_range(3) == 0) ? pick_time(base)
                                                   : TB_TIME'($urandom_range(int'(TIME_MAX),
                                                                             1000000)));
            if ($urandom_range(19) == 0) write_reg(CFG_IDX_SPARE_A, TB_TIME'($urandom()));
            set_idling(t_idle_mode'(blk % 4));
            for (n = 0; n < BLOCK_ITEMS; n++) queue_sample(pick_time(base));
            drain();
        end

        // Nothing is due any more; give a stray beat time to show up.
        set_idling(IDLE_NONE);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        fail_count += estimates_due.size();

        $display("Checked %0d timeout results from %0d RTT samples across %0d register writes,",
                 results_seen, items_taken, reg_writes);
        $display("with sender gaps and result stalls in every mix; %0d failures.", fail_count);
        if (fail_count == 0) begin
            $display("PASS rtt_timeout_estimator");
        end else begin
            $display("FAIL rtt_timeout_estimator");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rtt_pkg.sv
sv/rtt_blend.sv
sv/rtt_timeout_estimator.sv
tb/sv/rtt_timeout_estimator_tb.sv
